// File: hw/rtl/bisd_pkg.sv
package bisd_pkg;

   localparam int WordWidth  = 64;
   localparam int IndexWidth = 32;
   localparam int CountWidth = 31;

   localparam logic [CountWidth-1:0] MaxValuesReset = {CountWidth{1'b1}};
   localparam logic [IndexWidth-1:0] WordStride     = IndexWidth'(WordWidth);

   typedef enum logic [1:0] {
      ST_INDEX     = 2'd0,
      ST_NO_MARK   = 2'd1,
      ST_CAPACITY  = 2'd2,
      ST_FRAME_END = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

endpackage

// File: hw/rtl/bitmap_index_set_decoder.sv
// Bitmap index-set decoder.
// req_* carries one 64-bit frame word per beat: a header (count and bitmap mark
// in the low half, base index in the high half), then the bitmap words.
// rsp_* returns one decoded index per beat with last and a status code; an
// error or an empty final word gives a single beat with index 0.
// csr_wr_en/csr_wr_data set max_values, the per-frame index limit; write it
// only while the block is idle.
// A header or an empty final bitmap word produces its beat in rsp_* in the
// cycle after it is accepted; other empty bitmap words give no beat. A nonzero
// bitmap word is scanned one bit per cycle by a shift register and one shared
// 32-bit adder, holding at a set bit while the output register is busy; the
// next word can be taken once the highest set bit has been emitted. req_ready
// stays low while scanning. One index can leave per cycle if rsp_ready is high.
// A single output register sits on rsp_*; when the receiver stalls, the scan
// holds at the next set bit and no new word is taken until the beat drains.
// Reset (synchronous, active high) returns to expecting a header, clears the
// output valid and sets max_values to its maximum.
module bitmap_index_set_decoder
   import bisd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WordWidth-1:0]  req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IndexWidth-1:0] rsp_index,
   output logic                  rsp_last,
   output logic [1:0]            rsp_status,
   input  logic                  csr_wr_en,
   input  logic [CountWidth-1:0] csr_wr_data
);

   state_type               state_ff, state_in;
   logic                    in_bitmap_ff, in_bitmap_in;
   logic [CountWidth-1:0]   words_left_ff, words_left_in;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic                    aborted_ff, aborted_in;
   logic [CountWidth-1:0]   max_ff;
   logic [IndexWidth-1:0]   wbase_ff, wbase_in;
   logic [IndexWidth-1:0]   idx_ff, idx_in;
   logic [WordWidth-1:0]    shift_ff, shift_in;
   logic                    final_ff, final_in;
   logic                    rsp_valid_ff;
   logic [IndexWidth-1:0]   rsp_index_ff;
   logic                    rsp_last_ff;
   status_type              rsp_status_ff;

   logic                    out_free, accept, is_final, load;
   logic [IndexWidth-1:0]   ld_index;
   logic                    ld_last;
   status_type              ld_status;
   logic [IndexWidth-1:0]   add_a, add_b, add_sum;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign is_final  = (words_left_ff <= CountWidth'(1));
   assign add_sum   = add_a + add_b;

   always_comb begin
      state_in     = state_ff;
      in_bitmap_in = in_bitmap_ff;
      words_left_in = words_left_ff;
      count_in     = count_ff;
      aborted_in   = aborted_ff;
      wbase_in     = wbase_ff;
      idx_in       = idx_ff;
      shift_in     = shift_ff;
      final_in     = final_ff;
      load         = 1'b0;
      ld_index     = '0;
      ld_last      = 1'b0;
      ld_status    = ST_INDEX;
      add_a        = idx_ff;
      add_b        = IndexWidth'(1);
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (!in_bitmap_ff) begin
                  load    = 1'b1;
                  ld_last = 1'b1;
                  if (!req_word[31]) begin
                     ld_status = ST_NO_MARK;
                  end else begin
                     words_left_in = req_word[CountWidth-1:0];
                     in_bitmap_in  = (req_word[CountWidth-1:0] != '0);
                     add_a         = req_word[WordWidth-1:IndexWidth];
                     wbase_in      = add_sum;   // first bitmap index is base + 1
                     count_in      = '0;
                     aborted_in    = 1'b0;
                     if (max_ff == '0) begin
                        ld_status  = ST_CAPACITY;
                        aborted_in = 1'b1;
                     end else begin
                        ld_index = req_word[WordWidth-1:IndexWidth];
                        ld_last  = (req_word[CountWidth-1:0] == '0);
                        count_in = CountWidth'(1);
                     end
                  end
               end else begin
                  words_left_in = is_final ? '0 : words_left_ff - CountWidth'(1);
                  in_bitmap_in  = !is_final;
                  add_a         = wbase_ff;
                  add_b         = WordStride;
                  wbase_in      = add_sum;
                  idx_in        = wbase_ff;
                  if (!aborted_ff) begin
                     if (req_word == '0) begin
                        if (is_final) begin
                           load      = 1'b1;
                           ld_last   = 1'b1;
                           ld_status = ST_FRAME_END;
                        end
                     end else begin
                        shift_in = req_word;
                        final_in = is_final;
                        state_in = S_SCAN;
                     end
                  end
               end
            end
         end
         S_SCAN: begin
            // shift_ff is never zero here, so a clear bit 0 means more bits follow
            if (!shift_ff[0]) begin
               shift_in = shift_ff >> 1;
               idx_in   = add_sum;
            end else if (out_free) begin
               load = 1'b1;
               if (count_ff >= max_ff) begin
                  ld_last    = 1'b1;
                  ld_status  = ST_CAPACITY;
                  aborted_in = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  ld_index = idx_ff;
                  ld_last  = final_ff && (shift_ff[WordWidth-1:1] == '0);
                  count_in = count_ff + CountWidth'(1);
                  shift_in = shift_ff >> 1;
                  idx_in   = add_sum;
                  if (shift_ff[WordWidth-1:1] == '0) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         in_bitmap_ff  <= 1'b0;
         words_left_ff <= '0;
         count_ff      <= '0;
         aborted_ff    <= 1'b0;
         max_ff        <= MaxValuesReset;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_bitmap_ff  <= in_bitmap_in;
         words_left_ff <= words_left_in;
         count_ff      <= count_in;
         aborted_ff    <= aborted_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      wbase_ff <= wbase_in;
      idx_ff   <= idx_in;
      shift_ff <= shift_in;
      final_ff <= final_in;
      if (load) begin
         rsp_index_ff  <= ld_index;
         rsp_last_ff   <= ld_last;
         rsp_status_ff <= ld_status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// File: tb/sv/tb_bitmap_index_set_decoder.sv
module tb_bitmap_index_set_decoder;
   import bisd_pkg::*;

   typedef struct packed {
      logic [IndexWidth-1:0] value;
      logic                  is_last;
      status_type            code;
   } index_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WordWidth-1:0]  req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [IndexWidth-1:0] rsp_index;
   logic                  rsp_last;
   logic [1:0]            rsp_status;
   logic                  csr_wr_en = 1'b0;
   logic [CountWidth-1:0] csr_wr_data = '0;

   bitmap_index_set_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_index   (rsp_index),
      .rsp_last    (rsp_last),
      .rsp_status  (rsp_status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // decoder shadow: capacity register and frame state
   logic [CountWidth-1:0] capacity_limit   = MaxValuesReset;
   logic                  frame_open       = 1'b0;
   logic [CountWidth-1:0] frame_words_left = '0;
   logic [IndexWidth-1:0] frame_base       = '0;
   logic [CountWidth-1:0] frame_word_no    = '0;
   logic [31:0]           frame_count      = '0;
   logic                  frame_aborted    = 1'b0;

   index_beat_type        expected_beats[$];
   logic [WordWidth-1:0]  pending_words[$];
   int unsigned           words_queued   = 0;
   int unsigned           words_accepted = 0;
   int unsigned           error_count    = 0;
   logic                  word_taken     = 1'b0;
   int unsigned           send_idle_pct  = 29;
   int unsigned           recv_idle_pct  = 88;

   // stream position as seen by the generator; independent of capacity
   logic                  gen_in_bitmap    = 1'b0;
   logic [CountWidth-1:0] gen_words_left   = '0;

   task automatic report_mismatch(string msg);
      if (error_count < 200)
         $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic emit_index(logic [IndexWidth-1:0] value, logic is_last);
      if (frame_count >= 32'(capacity_limit)) begin
         expected_beats.push_back('{'0, 1'b1, ST_CAPACITY});
         frame_aborted = 1'b1;
         return 1'b0;
      end
      expected_beats.push_back('{value, is_last, ST_INDEX});
      frame_count++;
      return 1'b1;
   endfunction

   function automatic void decode_word(logic [WordWidth-1:0] w);
      logic [IndexWidth-1:0] offset;
      logic                  final_word;
      logic [WordWidth-1:0]  rest;
      if (!frame_open) begin
         if (!w[31]) begin
            expected_beats.push_back('{'0, 1'b1, ST_NO_MARK});
            return;
         end
         frame_base       = w[63:32];
         frame_words_left = w[30:0];
         frame_word_no    = '0;
         frame_count      = '0;
         frame_aborted    = 1'b0;
         void'(emit_index(frame_base, frame_words_left == 0));
         frame_open = (frame_words_left != 0);
         return;
      end
      final_word = (frame_words_left <= 1);
      offset = {frame_word_no[25:0], 6'd0};
      frame_words_left = frame_words_left - 1'b1;
      frame_word_no    = frame_word_no + 1'b1;
      if (final_word) begin
         frame_open       = 1'b0;
         frame_words_left = '0;
      end
      if (frame_aborted)
         return;
      if (w == 0) begin
         if (final_word)
            expected_beats.push_back('{'0, 1'b1, ST_FRAME_END});
         return;
      end
      for (int b = 0; b < WordWidth; b++) begin
         if (w[b]) begin
            rest = (b < WordWidth - 1) ? (w >> (b + 1)) : '0;
            if (!emit_index(frame_base + offset + 32'(b + 1), final_word && rest == 0))
               break;
         end
      end
   endfunction

   // monitor: checks result beats, predicts on accepted words
   always @(posedge clock) begin
      index_beat_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat index %h last %b status %0d",
                                         rsp_index, rsp_last, rsp_status));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_index !== want.value)
                  report_mismatch($sformatf("index %h, want %h", rsp_index, want.value));
               if (rsp_last !== want.is_last)
                  report_mismatch($sformatf("last %b, want %b (index %h)",
                                            rsp_last, want.is_last, want.value));
               if (rsp_status !== want.code)
                  report_mismatch($sformatf("status %0d, want %0d (index %h)",
                                            rsp_status, want.code, want.value));
            end
         end
         word_taken = req_valid && req_ready;
         if (word_taken) begin
            decode_word(req_word);
            words_accepted++;
         end
      end
   end

   // driver: word beats and result backpressure
   always @(negedge clock) begin
      logic                 next_valid;
      logic [WordWidth-1:0] next_word;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_word  = req_word;
         if (!req_valid || word_taken) begin
            next_valid = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word  = pending_words.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
         req_word  <= next_word;
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_word(logic [WordWidth-1:0] w);
      logic [WordWidth-1:0] v;
      v = w;
      if (!gen_in_bitmap) begin
         // keep stray headers short so a misaligned word cannot open a huge frame
         if (v[31] && v[30:0] > 16)
            v[30:4] = '0;
         if (v[31] && v[30:0] != 0) begin
            gen_in_bitmap  = 1'b1;
            gen_words_left = v[30:0];
         end
      end else begin
         gen_words_left = gen_words_left - 1'b1;
         if (gen_words_left == 0)
            gen_in_bitmap = 1'b0;
      end
      pending_words.push_back(v);
      words_queued++;
   endtask

   function automatic logic [WordWidth-1:0] bitmap_pattern();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 15)
         return '0;
      if (pick < 30)
         return 64'd1 << $urandom_range(63);
      if (pick < 55)
         return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      if (pick < 80)
         return {$urandom, $urandom};
      if (pick < 85)
         return '1;
      return {$urandom, $urandom} | {$urandom, $urandom};
   endfunction

   task automatic queue_random_traffic(int unsigned budget);
      int unsigned           sent;
      int unsigned           pick;
      int unsigned           words;
      int unsigned           cut;
      logic [IndexWidth-1:0] base;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         base = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF - $urandom_range(300) : $urandom;
         if (pick < 82) begin
            cut = $urandom_range(99);
            words = (cut < 10) ? 0 : (cut < 70) ? $urandom_range(3, 1) : $urandom_range(8, 4);
            queue_word({base, 1'b1, 31'(words)});
            repeat (words) queue_word(bitmap_pattern());
            sent += words + 1;
         end else if (pick < 90) begin
            queue_word({base, 1'b0, 31'($urandom)});
            sent++;
         end else if (pick < 96) begin
            // truncated frame: the next header lands in the bitmap
            words = $urandom_range(6, 2);
            cut   = $urandom_range(words - 1);
            queue_word({base, 1'b1, 31'(words)});
            repeat (cut) queue_word(bitmap_pattern());
            sent += cut + 1;
         end else begin
            queue_word({$urandom, $urandom});
            sent++;
         end
      end
   endtask

   // close any open frame, drain, then let a scan in progress finish
   task automatic settle();
      while (gen_in_bitmap)
         queue_word('0);
      do
         @(negedge clock);
      while (words_accepted != words_queued || expected_beats.size() != 0);
      repeat (70) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CountWidth-1:0] limit);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      capacity_limit = limit;
      @(posedge clock);
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default capacity
      queue_word({32'h1234_5678, 1'b0, 31'd5});
      queue_word({32'h0000_0000, 1'b1, 31'd0});
      queue_word({32'hFFFF_FFFF, 1'b1, 31'd0});
      queue_word({32'hFFFF_FFF0, 1'b1, 31'd1});
      queue_word('1);
      queue_word({32'd5, 1'b1, 31'd2});
      queue_word('0);
      queue_word('0);
      queue_word({32'd100, 1'b1, 31'd3});
      queue_word(64'h1);
      queue_word('0);
      queue_word(64'h8000_0000_0000_0001);
      queue_word({32'h8000_0000, 1'b1, 31'd2});
      queue_word(64'h8000_0000_0000_0000);
      queue_word(64'h5555_AAAA_0F0F_F0F0);

      // capacity hit mid-word, then at the first bitmap word
      write_capacity(31'd2);
      queue_word({32'd7, 1'b1, 31'd1});
      queue_word(64'h1F);
      queue_word({32'd9, 1'b1, 31'd2});
      queue_word('1);
      queue_word('1);

      // zero capacity: error already at the header
      write_capacity(31'd0);
      queue_word({32'd1, 1'b1, 31'd0});
      queue_word({32'd2, 1'b1, 31'd2});
      queue_word('1);
      queue_word('0);

      write_capacity(MaxValuesReset);
      queue_random_traffic(110);

      write_capacity(31'($urandom_range(8, 1)));
      send_idle_pct = 88;
      recv_idle_pct = 29;
      queue_random_traffic(110);

      write_capacity(31'($urandom_range(80, 9)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_traffic(90);

      write_capacity(31'd0);
      queue_random_traffic(25);

      write_capacity(31'd1);
      queue_random_traffic(35);

      settle();
      if (error_count == 0 && expected_beats.size() == 0)
         $display("bitmap_index_set_decoder verification clean");
      else
         $display("bitmap_index_set_decoder verification failed");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("bitmap_index_set_decoder verification failed");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/bisd_pkg.sv
hw/rtl/bitmap_index_set_decoder.sv
tb/sv/tb_bitmap_index_set_decoder.sv
